@@ hw/rtl/dps_pkg.sv @@
// ----------------------------------------------------------------------------
// dps_pkg
// Shared types and constants of the duration percentile summary core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dps_pkg;

    localparam int CAPACITY  = 256;
    localparam int ADDR_W    = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int DAT_W     = 31;
    localparam int FLD_W     = 32;
    localparam int OUT_CNT_W = 9;
    localparam int SUM_W     = DAT_W + CNT_W;
    localparam int SUB_W     = SUM_W + 1;
    localparam int STEP_W    = $clog2(SUM_W + 1);

    // floor(95*x/100) as x * (95 * ceil(2^26/100)) >> 26, exact for x < 98000
    localparam int P95_SHIFT = 26;
    localparam int P95_MUL   = ((1 << P95_SHIFT) + 99) / 100 * 95;
    localparam int P95_MUL_W = P95_SHIFT + 1;
    localparam int PROD_W    = CNT_W + P95_MUL_W;

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_FIN_IDX,
        S_RD_MED,
        S_RD_P95,
        S_RD_MAX,
        S_DIV_INIT,
        S_DIV,
        S_DONE
    } t_state;

endpackage

@@ hw/rtl/duration_percentile_summary_core.sv @@
// ----------------------------------------------------------------------------
// duration_percentile_summary_core
// add word: ignored if negative, dropped if the store is full; a stored one
// walks down past every stored sample larger than it, moving each one up.
// finish word: the summary word is formed by the one-bit-per-cycle divider,
// and the next word is accepted once it is loaded for output; an empty
// store skips the divider; a held summary word stalls the finish.
// reset clears control and counters synchronously; the store is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module duration_percentile_summary_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_command,
    input  logic signed [dps_pkg::FLD_W-1:0]  i_duration_ms,
    input  logic signed [dps_pkg::FLD_W-1:0]  i_cycle_duration_ms,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [dps_pkg::FLD_W-1:0]  o_cycle_time_out,
    output logic [dps_pkg::OUT_CNT_W-1:0]     o_samples_counted,
    output logic                              o_has_samples,
    output logic [dps_pkg::DAT_W-1:0]         o_median_ms,
    output logic [dps_pkg::DAT_W-1:0]         o_p95_ms,
    output logic [dps_pkg::DAT_W-1:0]         o_largest_ms,
    output logic [dps_pkg::DAT_W-1:0]         o_mean_ms,
    output logic                              o_overflowed
);

    localparam int FLD_W_T = dps_pkg::FLD_W;
    localparam int ADDR_W = dps_pkg::ADDR_W;
    localparam int CNT_W  = dps_pkg::CNT_W;
    localparam int DAT_W  = dps_pkg::DAT_W;
    localparam int SUM_W  = dps_pkg::SUM_W;
    localparam int SUB_W  = dps_pkg::SUB_W;
    localparam int STEP_W = dps_pkg::STEP_W;
    localparam int PROD_W = dps_pkg::PROD_W;
    localparam int OCW    = dps_pkg::OUT_CNT_W;

    // sample store, kept sorted ascending
    logic [DAT_W-1:0] r_mem [dps_pkg::CAPACITY];
    logic [DAT_W-1:0] r_rd_data;

    dps_pkg::t_state r_state, n_state;

    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_ovf, n_ovf;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [DAT_W-1:0]  r_val, n_val;
    logic [CNT_W-1:0]  r_j, n_j;
    logic [CNT_W-1:0]  r_n, n_n;
    logic              r_f_ovf, n_f_ovf;
    logic [FLD_W_T-1:0] r_cyc, n_cyc;
    logic [ADDR_W-1:0] r_p95_idx, n_p95_idx;
    logic [DAT_W-1:0]  r_med, n_med;
    logic [DAT_W-1:0]  r_p95, n_p95;
    logic [DAT_W-1:0]  r_max, n_max;
    logic [SUM_W-1:0]  r_rem, n_rem;
    logic [SUM_W-1:0]  r_quo, n_quo;
    logic [STEP_W-1:0] r_step, n_step;

    logic              r_out_valid;
    logic [FLD_W_T-1:0] r_o_cyc;
    logic [CNT_W-1:0]  r_o_n;
    logic              r_o_has;
    logic [DAT_W-1:0]  r_o_med, r_o_p95, r_o_max, r_o_mean;
    logic              r_o_ovf;

    logic              in_acc;
    logic              out_free;
    logic              out_load;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [DAT_W-1:0]  mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;

    logic [SUB_W-1:0]  sub_a, sub_b, sub_diff;
    logic              sub_borrow;
    logic [SUM_W-1:0]  rem_sh;
    logic [CNT_W-1:0]  j_m1, nm1, med_idx;
    logic [PROD_W-1:0] p95_prod;
    logic [CNT_W+OCW-1:0] n_ext;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign j_m1     = r_j - CNT_W'(1);
    assign nm1      = r_n - CNT_W'(1);
    assign med_idx  = nm1 >> 1;
    assign p95_prod = PROD_W'(nm1) * PROD_W'(dps_pkg::P95_MUL);
    assign rem_sh   = {r_rem[SUM_W-2:0], r_quo[SUM_W-1]};

    // shared subtractor: insert compare and restoring divide step
    always_comb begin
        sub_a = '0;
        sub_b = '0;
        case (r_state)
            dps_pkg::S_INS_CMP: begin
                sub_a = SUB_W'(r_val);
                sub_b = SUB_W'(r_rd_data);
            end
            dps_pkg::S_DIV: begin
                sub_a = SUB_W'(rem_sh);
                sub_b = SUB_W'(r_n);
            end
            default: begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
    end

    assign sub_diff   = sub_a - sub_b;
    assign sub_borrow = sub_diff[SUB_W-1];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dps_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (i_command == dps_pkg::CMD_FINISH) begin
                        n_state = (r_count == '0) ? dps_pkg::S_DONE : dps_pkg::S_FIN_IDX;
                    end else if (!i_duration_ms[FLD_W_T-1] &&
                                 r_count < CNT_W'(dps_pkg::CAPACITY)) begin
                        n_state = dps_pkg::S_INS_RD;
                    end
                end
            end
            dps_pkg::S_INS_RD: begin
                n_state = (r_j == '0) ? dps_pkg::S_IDLE : dps_pkg::S_INS_CMP;
            end
            dps_pkg::S_INS_CMP: begin
                n_state = sub_borrow ? dps_pkg::S_INS_RD : dps_pkg::S_IDLE;
            end
            dps_pkg::S_FIN_IDX:  n_state = dps_pkg::S_RD_MED;
            dps_pkg::S_RD_MED:   n_state = dps_pkg::S_RD_P95;
            dps_pkg::S_RD_P95:   n_state = dps_pkg::S_RD_MAX;
            dps_pkg::S_RD_MAX:   n_state = dps_pkg::S_DIV_INIT;
            dps_pkg::S_DIV_INIT: n_state = dps_pkg::S_DIV;
            dps_pkg::S_DIV: begin
                if (r_step == STEP_W'(1)) begin
                    n_state = dps_pkg::S_DONE;
                end
            end
            dps_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = dps_pkg::S_IDLE;
                end
            end
            default: n_state = dps_pkg::S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        o_in_ready = 1'b0;
        out_load   = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = r_j[ADDR_W-1:0];
        mem_wdata  = r_val;
        mem_raddr  = '0;
        n_count    = r_count;
        n_ovf      = r_ovf;
        n_sum      = r_sum;
        n_val      = r_val;
        n_j        = r_j;
        n_n        = r_n;
        n_f_ovf    = r_f_ovf;
        n_cyc      = r_cyc;
        n_p95_idx  = r_p95_idx;
        n_med      = r_med;
        n_p95      = r_p95;
        n_max      = r_max;
        n_rem      = r_rem;
        n_quo      = r_quo;
        n_step     = r_step;
        case (r_state)
            dps_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (in_acc) begin
                    if (i_command == dps_pkg::CMD_FINISH) begin
                        n_n     = r_count;
                        n_f_ovf = r_ovf;
                        n_cyc   = i_cycle_duration_ms;
                        n_med   = '0;
                        n_p95   = '0;
                        n_max   = '0;
                        n_rem   = '0;
                        n_quo   = (r_count == '0) ? '0 : r_sum;
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_sum   = '0;
                    end else if (!i_duration_ms[FLD_W_T-1]) begin
                        if (r_count < CNT_W'(dps_pkg::CAPACITY)) begin
                            n_val   = i_duration_ms[DAT_W-1:0];
                            n_j     = r_count;
                            n_count = r_count + CNT_W'(1);
                            n_sum   = r_sum + SUM_W'(i_duration_ms[DAT_W-1:0]);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                end
            end
            dps_pkg::S_INS_RD: begin
                if (r_j == '0) begin
                    mem_we = 1'b1;
                end else begin
                    mem_raddr = j_m1[ADDR_W-1:0];
                end
            end
            dps_pkg::S_INS_CMP: begin
                // larger neighbor moves up one place
                mem_we = 1'b1;
                if (sub_borrow) begin
                    mem_wdata = r_rd_data;
                    n_j       = j_m1;
                end
            end
            dps_pkg::S_FIN_IDX: begin
                n_p95_idx = p95_prod[dps_pkg::P95_SHIFT +: ADDR_W];
            end
            dps_pkg::S_RD_MED: begin
                mem_raddr = med_idx[ADDR_W-1:0];
            end
            dps_pkg::S_RD_P95: begin
                n_med     = r_rd_data;
                mem_raddr = r_p95_idx;
            end
            dps_pkg::S_RD_MAX: begin
                n_p95     = r_rd_data;
                mem_raddr = nm1[ADDR_W-1:0];
            end
            dps_pkg::S_DIV_INIT: begin
                n_max  = r_rd_data;
                n_step = STEP_W'(SUM_W);
            end
            dps_pkg::S_DIV: begin
                n_rem  = sub_borrow ? rem_sh : sub_diff[SUM_W-1:0];
                n_quo  = {r_quo[SUM_W-2:0], !sub_borrow};
                n_step = r_step - STEP_W'(1);
            end
            dps_pkg::S_DONE: begin
                out_load = out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dps_pkg::S_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_sum       <= n_sum;
            r_out_valid <= out_load ? 1'b1 : (r_out_valid && !i_out_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        r_val     <= n_val;
        r_j       <= n_j;
        r_n       <= n_n;
        r_f_ovf   <= n_f_ovf;
        r_cyc     <= n_cyc;
        r_p95_idx <= n_p95_idx;
        r_med     <= n_med;
        r_p95     <= n_p95;
        r_max     <= n_max;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_step    <= n_step;
        if (out_load) begin
            r_o_cyc  <= r_cyc;
            r_o_n    <= r_n;
            r_o_has  <= (r_n != '0);
            r_o_med  <= r_med;
            r_o_p95  <= r_p95;
            r_o_max  <= r_max;
            r_o_mean <= r_quo[DAT_W-1:0];
            r_o_ovf  <= r_f_ovf;
        end
    end

    assign n_ext             = {{OCW{1'b0}}, r_o_n};
    assign o_out_valid       = r_out_valid;
    assign o_cycle_time_out  = r_o_cyc;
    assign o_samples_counted = n_ext[OCW-1:0];
    assign o_has_samples     = r_o_has;
    assign o_median_ms       = r_o_med;
    assign o_p95_ms          = r_o_p95;
    assign o_largest_ms      = r_o_max;
    assign o_mean_ms         = r_o_mean;
    assign o_overflowed      = r_o_ovf;

`ifndef SYNTH
    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(dps_pkg::CAPACITY))
        else $error("sample count beyond capacity");

    a_store_cleared_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == dps_pkg::S_DIV |-> (r_count == '0 && !r_ovf))
        else $error("store not emptied after finish");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_has) |->
            (r_o_med <= r_o_p95 && r_o_p95 <= r_o_max && r_o_mean <= r_o_max))
        else $error("summary values out of order");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_o_has) |->
            (r_o_med == '0 && r_o_p95 == '0 && r_o_max == '0 && r_o_mean == '0))
        else $error("empty summary carries nonzero values");
`endif

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Checks duration_percentile_summary_core: sample words and finish words go
// in under random idle bursts and output stalls, and every summary word that
// comes out is compared field by field with an in-bench model of the store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT  = 5_000_000;
    // a sample insert can walk the whole store
    localparam int DRAIN_CYCLES = 2 * dps_pkg::CAPACITY + 100;

    typedef struct packed {
        logic [31:0] cycle_time;
        logic [8:0]  count;
        logic        has;
        logic [30:0] median;
        logic [30:0] p95;
        logic [30:0] largest;
        logic [30:0] mean;
        logic        ovf;
    } t_summary;

    logic        i_clk;
    logic        i_rst_n             = 1'b0;
    logic        i_in_valid          = 1'b0;
    logic        i_command           = dps_pkg::CMD_ADD;
    logic [31:0] i_duration_ms       = '0;
    logic [31:0] i_cycle_duration_ms = '0;
    logic        i_out_ready         = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [31:0] o_cycle_time_out;
    logic [8:0]  o_samples_counted;
    logic        o_has_samples;
    logic [30:0] o_median_ms;
    logic [30:0] o_p95_ms;
    logic [30:0] o_largest_ms;
    logic [30:0] o_mean_ms;
    logic        o_overflowed;

    t_summary    pending_summaries[$];
    logic [30:0] held_samples[$];
    logic        drop_seen  = 1'b0;
    bit          quiet_tail = 1'b0;
    int          sent_words = 0;
    int          errors     = 0;
    int          cycles     = 0;
    int          hold_cnt   = 0;

    duration_percentile_summary_core u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_command           (i_command),
        .i_duration_ms       (i_duration_ms),
        .i_cycle_duration_ms (i_cycle_duration_ms),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_cycle_time_out    (o_cycle_time_out),
        .o_samples_counted   (o_samples_counted),
        .o_has_samples       (o_has_samples),
        .o_median_ms         (o_median_ms),
        .o_p95_ms            (o_p95_ms),
        .o_largest_ms        (o_largest_ms),
        .o_mean_ms           (o_mean_ms),
        .o_overflowed        (o_overflowed)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("duration_percentile_summary_core: mismatch");
            $finish;
        end
    end

    // store model: negative samples vanish, a full store drops and flags
    function automatic void take_sample(input logic [31:0] dur);
        if (dur[31]) return;
        if (held_samples.size() < dps_pkg::CAPACITY)
            held_samples.insert(held_samples.size(), dur[30:0]);
        else drop_seen = 1'b1;
    endfunction

    function automatic t_summary close_cycle(input logic [31:0] cyc);
        logic [30:0] srt[$];
        logic [30:0] v;
        logic [63:0] total;
        logic [63:0] avg;
        int          n;
        int          j;
        t_summary    s;
        srt   = held_samples;
        n     = srt.size();
        total = '0;
        s     = '0;
        for (int i = 1; i < n; i++) begin
            v = srt[i];
            j = i;
            while (j > 0 && srt[j-1] > v) begin
                srt[j] = srt[j-1];
                j--;
            end
            srt[j] = v;
        end
        for (int i = 0; i < n; i++) total += srt[i];
        s.cycle_time = cyc;
        s.count      = n[8:0];
        s.ovf        = drop_seen;
        if (n > 0) begin
            avg       = total / n;
            s.has     = 1'b1;
            s.median  = srt[(50 * (n - 1)) / 100];
            s.p95     = srt[(95 * (n - 1)) / 100];
            s.largest = srt[n-1];
            s.mean    = avg[30:0];
        end
        held_samples.delete();
        drop_seen = 1'b0;
        return s;
    endfunction

    function automatic void check_field(input string fld, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $display("%0t %s expected %0h actual %0h", $time, fld, want, got);
            errors++;
        end
    endfunction

    // result checker and output stall generator
    always @(posedge i_clk) begin
        t_summary s;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_summaries.size() == 0) begin
                $display("%0t summary word with none expected, count expected none actual %0d",
                         $time, o_samples_counted);
                errors++;
            end else begin
                s = pending_summaries.pop_front();
                check_field("cycle_time_out",  s.cycle_time, o_cycle_time_out);
                check_field("samples_counted", s.count,      o_samples_counted);
                check_field("has_samples",     s.has,        o_has_samples);
                check_field("median_ms",       s.median,     o_median_ms);
                check_field("p95_ms",          s.p95,        o_p95_ms);
                check_field("largest_ms",      s.largest,    o_largest_ms);
                check_field("mean_ms",         s.mean,       o_mean_ms);
                check_field("overflowed",      s.ovf,        o_overflowed);
            end
        end
        if (quiet_tail) begin
            i_out_ready <= 1'b1;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if (i_out_ready && $urandom_range(0, 2) == 0) begin
            i_out_ready <= 1'b0;
            hold_cnt    <= $urandom_range(0, 8);
        end else begin
            i_out_ready <= 1'b1;
            hold_cnt    <= $urandom_range(1, 40);
        end
    end

    task automatic send_word(input logic cmd, input logic [31:0] dur, input logic [31:0] cyc);
        i_in_valid          <= 1'b1;
        i_command           <= cmd;
        i_duration_ms       <= dur;
        i_cycle_duration_ms <= cyc;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sent_words++;
        if (cmd == dps_pkg::CMD_FINISH)
            pending_summaries.insert(pending_summaries.size(), close_cycle(cyc));
        else take_sample(dur);
    endtask

    task automatic idle_gap(input int pct);
        if (!quiet_tail && $urandom_range(1, 100) <= pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] rand_sample();
        logic [31:0] r;
        int          pick;
        r    = $urandom();
        pick = $urandom_range(0, 99);
        if (pick < 10) return {1'b1, r[30:0]};
        if (pick < 30) return {28'd0, r[3:0]};
        if (pick < 38) return r[0] ? 32'h7FFF_FFFF : 32'd0;
        return {1'b0, r[30:0]};
    endfunction

    task automatic add_word(input logic [31:0] dur);
        send_word(dps_pkg::CMD_ADD, dur, $urandom());
    endtask

    task automatic finish_word(input logic [31:0] cyc);
        send_word(dps_pkg::CMD_FINISH, $urandom(), cyc);
    endtask

    task automatic test_directed();
        finish_word(32'd0);                 // empty store
        add_word(32'h8000_0000);            // negatives are ignored
        add_word(32'hFFFF_FFFF);
        finish_word(32'h8000_0000);
        add_word(32'h7FFF_FFFF);            // single sample
        finish_word(32'h7FFF_FFFF);
        add_word(32'd0);
        add_word(32'h7FFF_FFFF);
        add_word(32'h7FFF_FFFF);
        add_word(32'd0);
        finish_word(32'hFFFF_FFFF);
        add_word(32'd5);
        add_word(32'd3);
        add_word(32'h8000_0005);
        add_word(32'd9);
        add_word(32'd1);
        add_word(32'd7);
        finish_word(32'd12345);
        finish_word(32'h5555_AAAA);         // back-to-back finish
    endtask

    task automatic test_store_full();
        for (int k = 0; k < dps_pkg::CAPACITY; k++) begin
            add_word($urandom_range(0, 1) ? 32'h7FFF_FFFF : {1'b0, 31'($urandom())});
            idle_gap(15);
        end
        add_word(32'h7FFF_FFFF);            // dropped, sets overflow
        add_word(32'd0);
        add_word(32'hC000_0000);            // negative while full
        finish_word($urandom());
        finish_word($urandom());            // overflow must be cleared again
    endtask

    task automatic test_random_mix(input int target);
        int n;
        int pick;
        int gap_pct;
        while (sent_words < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) n = $urandom_range(dps_pkg::CAPACITY - 6, dps_pkg::CAPACITY + 14);
            else if (pick < 15) n = $urandom_range(21, 60);
            else n = $urandom_range(0, 20);
            case ($urandom_range(0, 2))
                0:       gap_pct = 0;
                1:       gap_pct = 10;
                default: gap_pct = 40;
            endcase
            for (int k = 0; k < n; k++) begin
                add_word(rand_sample());
                idle_gap(gap_pct);
            end
            finish_word($urandom());
            idle_gap(gap_pct);
        end
    endtask

    task automatic test_drain_pause();
        for (int k = 0; k < 5; k++) add_word(rand_sample());
        finish_word($urandom());
        for (int k = 0; k < 4; k++) add_word(rand_sample());
        // hold off with samples still stored until every summary is back
        i_in_valid <= 1'b0;
        while (pending_summaries.size() != 0) @(posedge i_clk);
        for (int k = 0; k < 4; k++) add_word(rand_sample());
        finish_word($urandom());
    endtask

    task automatic test_no_gaps(input int target);
        quiet_tail = 1'b1;
        test_random_mix(target);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_store_full();
        test_random_mix(900);
        test_drain_pause();
        test_random_mix(1750);
        test_no_gaps(1950);
        i_in_valid <= 1'b0;
        while (pending_summaries.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("duration_percentile_summary_core: match");
        end else begin
            $display("duration_percentile_summary_core: mismatch");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/dps_pkg.sv
hw/rtl/duration_percentile_summary_core.sv
sim/tb.sv
